/* src/mtra_pkg.sv */
// Package for the memory-type range allocator: beat types, status codes,
// memory type codes, scan token and table write types. No dependencies.
`default_nettype none

package mtra_pkg;

    localparam int SEL_W = 8;

    localparam logic [63:0] MIN_ADDR   = 64'h0000_0000_0010_0000;
    localparam logic [63:0] MIN_LEN    = 64'h0000_0000_0000_1000;
    localparam logic [63:0] VALID_BIT  = 64'h0000_0000_0000_0800;
    localparam logic [63:0] TYPE_FIELD = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] LOW_PAGE   = 64'h0000_0000_0000_0FFF;
    localparam logic [15:0] REFS_MAX   = 16'hFFFF;

    localparam logic [6:0] PAB_MIN = 7'd36;
    localparam logic [6:0] PAB_MAX = 7'd64;

    localparam logic [1:0] REG_ENABLED  = 2'd0;
    localparam logic [1:0] REG_PAB      = 2'd1;
    localparam logic [1:0] REG_WC       = 2'd2;
    localparam logic [1:0] REG_ENTRIES  = 2'd3;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [7:0] T_UC = 8'd0;
    localparam logic [7:0] T_WC = 8'd1;
    localparam logic [7:0] T_WT = 8'd4;
    localparam logic [7:0] T_WP = 8'd5;
    localparam logic [7:0] T_WB = 8'd6;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_NO_SPACE      = 3'd1,
        ST_NOT_SUPPORTED = 3'd2,
        ST_INVALID       = 3'd3,
        ST_NOT_FOUND     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OV_NONE,
        OV_MATCH,
        OV_CONFLICT
    } t_ov;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [63:0] address;
        logic [63:0] length;
        logic [7:0]  mem_type;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  entry_index;
        logic        hw_update;
        logic [63:0] base_word;
        logic [63:0] mask_word;
    } t_rsp;

    // request travelling down the cell row
    typedef struct packed {
        logic             active;
        logic             op;
        logic [63:0]      addr;
        logic [63:0]      len;
        logic [7:0]       mtype;
        logic             done;
        logic             have;
        logic [SEL_W-1:0] sel;
        logic [63:0]      sbase;
        logic [63:0]      smask;
        logic [15:0]      srefs;
    } t_tok;

    typedef struct packed {
        logic             en;
        logic [SEL_W-1:0] idx;
        logic [63:0]      base;
        logic [63:0]      mask;
        logic [15:0]      refs;
    } t_wr;

endpackage

`default_nettype wire

/* src/mtra_cell.sv */
// One table entry of the range allocator plus one stage of the scan row.
// Depends on mtra_pkg.
`default_nettype none

module mtra_cell #(
    parameter int INDEX = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire mtra_pkg::t_tok          i_tok,
    output mtra_pkg::t_tok               o_tok,
    input  wire mtra_pkg::t_wr           i_wr,
    input  wire [mtra_pkg::SEL_W-1:0]    i_count,
    input  wire [63:0]                   i_pmask,
    input  wire [63:0]                   i_bmask
);

    logic [63:0]    r_base;
    logic [63:0]    r_mask;
    logic [15:0]    r_refs;
    mtra_pkg::t_tok r_tok;
    mtra_pkg::t_tok n_tok;

    logic [63:0]   w_va;
    logic [63:0]   w_vlm1;
    logic [7:0]    w_vt;
    logic          w_hit;
    logic          w_ident;
    mtra_pkg::t_ov w_ov;
    logic          w_here;

    assign w_va   = r_base & i_bmask;
    assign w_vt   = r_base[7:0];
    assign w_vlm1 = ~(r_mask & i_bmask) & i_pmask;
    assign w_hit  = ((w_va >= i_tok.addr) && ((w_va - i_tok.addr) < i_tok.len)) ||
                    ((i_tok.addr >= w_va) && ((i_tok.addr - w_va) <= w_vlm1));
    assign w_ident = (w_va == i_tok.addr) && (i_tok.len != 64'd0) &&
                     ((i_tok.len - 64'd1) == w_vlm1) && (w_vt == i_tok.mtype);

    always_comb begin
        if (!w_hit) begin
            w_ov = mtra_pkg::OV_NONE;
        end else if (w_ident) begin
            w_ov = mtra_pkg::OV_MATCH;
        end else if ((w_vt == mtra_pkg::T_UC && i_tok.mtype == mtra_pkg::T_UC) ||
                     (w_vt == mtra_pkg::T_UC && i_tok.mtype == mtra_pkg::T_WB) ||
                     (w_vt == mtra_pkg::T_WB && i_tok.mtype == mtra_pkg::T_UC)) begin
            w_ov = mtra_pkg::OV_NONE;
        end else begin
            w_ov = mtra_pkg::OV_CONFLICT;
        end
    end

    assign w_here = i_tok.active && !i_tok.done &&
                    (mtra_pkg::SEL_W'(INDEX) < i_count);

    always_comb begin
        n_tok = i_tok;
        if (w_here) begin
            if (i_tok.op == mtra_pkg::OP_ADD) begin
                // free entries are remembered; the last one seen wins
                if (r_refs == 16'd0) begin
                    n_tok.have  = 1'b1;
                    n_tok.sel   = mtra_pkg::SEL_W'(INDEX);
                    n_tok.sbase = r_base;
                    n_tok.smask = r_mask;
                    n_tok.srefs = r_refs;
                end else if (w_ov == mtra_pkg::OV_MATCH) begin
                    n_tok.have  = 1'b1;
                    n_tok.done  = 1'b1;
                    n_tok.sel   = mtra_pkg::SEL_W'(INDEX);
                    n_tok.sbase = r_base;
                    n_tok.smask = r_mask;
                    n_tok.srefs = r_refs;
                end else if (w_ov == mtra_pkg::OV_CONFLICT) begin
                    n_tok.have = 1'b0;
                    n_tok.done = 1'b1;
                end
            end else if (r_refs != 16'd0 && w_ov == mtra_pkg::OV_MATCH) begin
                n_tok.have  = 1'b1;
                n_tok.done  = 1'b1;
                n_tok.sel   = mtra_pkg::SEL_W'(INDEX);
                n_tok.sbase = r_base;
                n_tok.smask = r_mask;
                n_tok.srefs = r_refs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_base <= '0;
            r_mask <= '0;
            r_refs <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && i_wr.idx == mtra_pkg::SEL_W'(INDEX)) begin
                r_base <= i_wr.base;
                r_mask <= i_wr.mask;
                r_refs <= i_wr.refs;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* src/memory_type_range_allocator_unit.sv */
// Memory-type range allocator: one request at a time scanned down a row of entry cells.
// The input stalls from acceptance until the result has moved to the output register, so
// no new request is taken before the last one is through; each token walks the whole cell row.
// Requests refused by the early checks skip the scan. The output register holds a
// result while the next request is taken. Reset clears config to defaults and frees all
// table entries at once.
`default_nettype none

module memory_type_range_allocator_unit #(
    parameter int ENTRIES = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire mtra_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output mtra_pkg::t_rsp      o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [1:0]           i_cfg_index,
    input  wire [6:0]           i_cfg_data
);

    // config
    logic       r_enabled;
    logic [6:0] r_pab;
    logic       r_wc;
    logic [3:0] r_eiu;

    mtra_pkg::t_state r_state;
    mtra_pkg::t_state n_state;
    mtra_pkg::t_tok   r_launch;
    mtra_pkg::t_tok   n_launch;
    mtra_pkg::t_rsp   r_res;
    mtra_pkg::t_rsp   n_res;
    mtra_pkg::t_rsp   r_out;
    logic             r_out_valid;
    logic             n_out_load;
    mtra_pkg::t_wr    w_wr;

    mtra_pkg::t_tok w_tok [ENTRIES+1];

    logic [6:0]                  w_pab;
    logic [63:0]                 w_pmask;
    logic [63:0]                 w_bmask;
    logic [mtra_pkg::SEL_W-1:0]  w_count;
    logic                        w_accept;
    logic                        w_pre_fail;
    mtra_pkg::t_status           w_pre_status;
    logic                        w_type_ok;
    logic [63:0]                 w_lowbit;
    logic                        w_out_free;
    mtra_pkg::t_tok              w_exit;
    logic [63:0]                 w_enc_base;
    logic [63:0]                 w_enc_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_pab     <= 7'd36;
            r_wc      <= 1'b0;
            r_eiu     <= 4'd8;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mtra_pkg::REG_ENABLED: r_enabled <= i_cfg_data[0];
                mtra_pkg::REG_PAB:     r_pab     <= i_cfg_data;
                mtra_pkg::REG_WC:      r_wc      <= i_cfg_data[0];
                mtra_pkg::REG_ENTRIES: r_eiu     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_pab < mtra_pkg::PAB_MIN) begin
            w_pab = mtra_pkg::PAB_MIN;
        end else if (r_pab > mtra_pkg::PAB_MAX) begin
            w_pab = mtra_pkg::PAB_MAX;
        end else begin
            w_pab = r_pab;
        end
        if (w_pab == mtra_pkg::PAB_MAX) begin
            w_pmask = '1;
        end else begin
            w_pmask = (64'd1 << w_pab[5:0]) - 64'd1;
        end
        w_bmask = w_pmask & ~mtra_pkg::LOW_PAGE;
        if (ENTRIES < int'(r_eiu)) begin
            w_count = mtra_pkg::SEL_W'(ENTRIES);
        end else begin
            w_count = mtra_pkg::SEL_W'(r_eiu);
        end
    end

    // early checks of an add, in order
    assign w_type_ok = (i_in_data.mem_type == mtra_pkg::T_UC) ||
                       (i_in_data.mem_type == mtra_pkg::T_WC) ||
                       (i_in_data.mem_type == mtra_pkg::T_WT) ||
                       (i_in_data.mem_type == mtra_pkg::T_WP) ||
                       (i_in_data.mem_type == mtra_pkg::T_WB);
    assign w_lowbit  = i_in_data.address & (~i_in_data.address + 64'd1);

    always_comb begin
        w_pre_fail   = 1'b1;
        w_pre_status = mtra_pkg::ST_NOT_SUPPORTED;
        if (!r_enabled) begin
            w_pre_status = mtra_pkg::ST_NOT_SUPPORTED;
        end else if (i_in_data.operation == mtra_pkg::OP_REMOVE) begin
            w_pre_fail = 1'b0;
        end else if (!w_type_ok) begin
            w_pre_status = mtra_pkg::ST_INVALID;
        end else if (i_in_data.mem_type == mtra_pkg::T_WC && !r_wc) begin
            w_pre_status = mtra_pkg::ST_NOT_SUPPORTED;
        end else if (i_in_data.address < mtra_pkg::MIN_ADDR ||
                     w_count == '0) begin
            w_pre_status = mtra_pkg::ST_NOT_SUPPORTED;
        end else if (i_in_data.length < mtra_pkg::MIN_LEN ||
                     (i_in_data.length & (i_in_data.length - 64'd1)) != 64'd0 ||
                     i_in_data.length > w_lowbit) begin
            w_pre_status = mtra_pkg::ST_INVALID;
        end else begin
            w_pre_fail = 1'b0;
        end
    end

    assign w_tok[0] = r_launch;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mtra_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .o_tok  (w_tok[g+1]),
            .i_wr   (w_wr),
            .i_count(w_count),
            .i_pmask(w_pmask),
            .i_bmask(w_bmask)
        );
    end

    assign w_exit     = w_tok[ENTRIES];
    assign w_enc_base = (w_exit.addr & w_bmask) | {56'd0, w_exit.mtype};
    assign w_enc_mask = ~(w_exit.len - 64'd1) & w_bmask;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtra_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_pre_fail ? mtra_pkg::S_RESULT : mtra_pkg::S_SCAN;
                end
            end
            mtra_pkg::S_SCAN: begin
                if (w_exit.active) begin
                    n_state = mtra_pkg::S_RESULT;
                end
            end
            mtra_pkg::S_RESULT: begin
                if (w_out_free) begin
                    n_state = mtra_pkg::S_IDLE;
                end
            end
            default: n_state = mtra_pkg::S_IDLE;
        endcase
    end

    // outputs of each state
    always_comb begin
        o_in_stall = 1'b1;
        n_launch   = '0;
        n_res      = r_res;
        n_out_load = 1'b0;
        w_wr       = '0;
        unique case (r_state)
            mtra_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (w_accept) begin
                    if (w_pre_fail) begin
                        n_res        = '0;
                        n_res.status = w_pre_status;
                    end else begin
                        n_launch.active = 1'b1;
                        n_launch.op     = i_in_data.operation;
                        n_launch.addr   = i_in_data.address;
                        n_launch.len    = i_in_data.length;
                        n_launch.mtype  = i_in_data.mem_type;
                    end
                end
            end
            mtra_pkg::S_SCAN: begin
                if (w_exit.active) begin
                    n_res       = '0;
                    w_wr.idx    = w_exit.sel;
                    w_wr.base   = w_exit.sbase;
                    w_wr.mask   = w_exit.smask;
                    if (!w_exit.have) begin
                        n_res.status = (w_exit.op == mtra_pkg::OP_ADD) ?
                                       mtra_pkg::ST_NO_SPACE : mtra_pkg::ST_NOT_FOUND;
                    end else begin
                        w_wr.en           = 1'b1;
                        n_res.status      = mtra_pkg::ST_OK;
                        n_res.entry_index = w_exit.sel[2:0];
                        n_res.base_word   = w_exit.sbase;
                        n_res.mask_word   = w_exit.smask;
                        if (w_exit.op == mtra_pkg::OP_ADD) begin
                            if (w_exit.srefs == 16'd0) begin
                                w_wr.base       = w_enc_base;
                                w_wr.mask       = w_enc_mask | mtra_pkg::VALID_BIT;
                                w_wr.refs       = 16'd1;
                                n_res.hw_update = 1'b1;
                                n_res.base_word = w_wr.base;
                                n_res.mask_word = w_wr.mask;
                            end else if (w_exit.srefs == mtra_pkg::REFS_MAX) begin
                                w_wr.refs = w_exit.srefs;
                            end else begin
                                w_wr.refs = w_exit.srefs + 16'd1;
                            end
                        end else begin
                            w_wr.refs = w_exit.srefs - 16'd1;
                            if (w_wr.refs == 16'd0) begin
                                // last reference gone: re-encode without valid bit
                                w_wr.base       = w_enc_base;
                                w_wr.mask       = w_enc_mask;
                                n_res.hw_update = 1'b1;
                                n_res.base_word = w_wr.base;
                                n_res.mask_word = w_wr.mask;
                            end
                        end
                    end
                end
            end
            mtra_pkg::S_RESULT: begin
                n_out_load = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtra_pkg::S_IDLE;
            r_launch    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (n_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
